[rtl/tqcr_pkg.sv]
// ----------------------------------------------------------------------------
// tqcr_pkg: shared constants for the two-queue cache replacement tracker
// Widths, reset capacities, configuration register indexes, queue selectors and lookup result codes.
// ----------------------------------------------------------------------------
package tqcr_pkg;

  localparam int KEY_W        = 32;
  localparam int CAP_W        = 7;
  localparam int DEF_DEPTH    = 64;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CAP_W-1:0] RESET_RECENT_CAP   = 7'd64;
  localparam logic [CAP_W-1:0] RESET_FREQUENT_CAP = 7'd16;
  localparam logic [CAP_W-1:0] RESET_GHOST_CAP    = 7'd40;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RECENT_CAP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQUENT_CAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GHOST_CAP    = 2'd2;

  // queue selectors
  typedef enum logic [1:0] {
    QSEL_GHOST    = 2'd0,
    QSEL_RECENT   = 2'd1,
    QSEL_FREQUENT = 2'd2
  } qsel_t;

  // found codes
  localparam logic [1:0] FOUND_NONE     = 2'd0;
  localparam logic [1:0] FOUND_GHOST    = 2'd1;
  localparam logic [1:0] FOUND_RECENT   = 2'd2;
  localparam logic [1:0] FOUND_FREQUENT = 2'd3;

endpackage

[rtl/tqcr_queue.sv]
// ----------------------------------------------------------------------------
// tqcr_queue: one key queue held in a memory
// One read port and one write port; the sequencer walks addresses.
// ----------------------------------------------------------------------------
module tqcr_queue #(
  parameter int DEPTH = tqcr_pkg::DEF_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [tqcr_pkg::KEY_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [tqcr_pkg::KEY_W-1:0] rd_data
);
  import tqcr_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/two_queue_cache_replacement_top.sv]
// ----------------------------------------------------------------------------
// two_queue_cache_replacement_top: 2Q replacement tracker
// Ghost, recent and frequent key queues searched and compacted in sequence.
// ----------------------------------------------------------------------------
// Usage: each input item on in_* carries one block key. The block searches
// the ghost, recent and frequent queues in that order, reading and comparing
// one entry before reading the next, stops at a found key, removes it by
// shifting later entries down one slot (each read, then written), then
// appends the key to the frequent or recent queue (a key dropped from a
// full recent queue is appended to the ghost queue). One result item, hit
// and found queue, is given on out_* per input item.
// A miss scans all three queues, then may drop the oldest key from a full
// recent queue and from a full ghost queue; the single read port of each
// queue memory sets the pace. One item is processed at a time; in_tready
// is low from accept until the result register is loaded. The result sits
// in an output register; a stalled receiver holds it and the next item is
// accepted meanwhile but its result waits until the register is free.
// Reset: synchronous, active low; all queues empty, capacities 64/16/40.
// Configuration writes on cfg_* take effect at once; write only when idle.
// ----------------------------------------------------------------------------
module two_queue_cache_replacement_top #(
  parameter int QUEUE_DEPTH = tqcr_pkg::DEF_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // block_key[31:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // hit[0], found_queue[2:1]
  input  logic                          cfg_we,
  input  logic [tqcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tqcr_pkg::CAP_W-1:0]    cfg_data
);
  import tqcr_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_CMP, ST_SH_RD, ST_SH_WR, ST_APPEND,
    ST_DROP_RD, ST_DROP_WAIT, ST_DROP_SH_RD, ST_DROP_SH_WR, ST_TAIL, ST_DONE
  } state_t;

  state_t             state_r;
  logic [CAP_W-1:0]   cap_r [3];
  logic [CW-1:0]      cnt_r [3];
  qsel_t              q_r;        // queue under scan, shift, append or drop
  logic [CW-1:0]      idx_r;
  logic [KEY_W-1:0]   key_r;      // key being placed
  logic [KEY_W-1:0]   orig_r;     // accessed key
  logic [1:0]         found_r;
  logic               ghost_pend_r;
  logic [KEY_W-1:0]   drop_r;
  logic               busy_r;
  logic               res_v_r;
  logic [1:0]         res_found_r;

  logic [2:0]         we;
  logic [AW-1:0]      wa [3];
  logic [KEY_W-1:0]   wd [3];
  logic [AW-1:0]      ra;
  logic [KEY_W-1:0]   rd [3];
  logic [KEY_W-1:0]   rsel;
  logic [CW-1:0]      cap_eff;
  logic [CAP_W-1:0]   cap_raw;

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_q
      tqcr_queue #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_q (
        .clk(clk), .wr_en(we[g]), .wr_addr(wa[g]), .wr_data(wd[g]),
        .rd_addr(ra), .rd_data(rd[g]));
    end
  endgenerate

  // effective capacity of the queue named by q_r
  always_comb begin
    cap_raw = cap_r[q_r];
    if (cap_raw == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_raw) > 32'(QUEUE_DEPTH)) begin
      cap_eff = DEPTH_C;
    end else begin
      cap_eff = CW'(cap_raw);
    end
  end

  assign rsel = rd[q_r];
  assign ra   = (state_r == ST_SH_RD || state_r == ST_DROP_SH_RD) ?
                AW'(idx_r + CW'(1)) : AW'(idx_r);

  // memory writes
  always_comb begin
    we = '0;
    for (int i = 0; i < 3; i++) begin
      wa[i] = AW'(idx_r);
      wd[i] = rsel;
    end
    if (state_r == ST_SH_WR || state_r == ST_DROP_SH_WR) begin
      we[q_r] = 1'b1;
    end else if (state_r == ST_TAIL && cnt_r[q_r] < DEPTH_C) begin
      we[q_r] = 1'b1;
      wa[q_r] = AW'(cnt_r[q_r]);
      wd[q_r] = key_r;
    end
  end

  assign in_tready  = rst_n && !busy_r;
  assign out_tvalid = res_v_r;
  assign out_tdata  = {5'd0, res_found_r, (res_found_r == FOUND_RECENT ||
                                           res_found_r == FOUND_FREQUENT)};

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      busy_r       <= 1'b0;
      res_v_r      <= 1'b0;
      cap_r[0]     <= RESET_GHOST_CAP;
      cap_r[1]     <= RESET_RECENT_CAP;
      cap_r[2]     <= RESET_FREQUENT_CAP;
      for (int i = 0; i < 3; i++) cnt_r[i] <= '0;
      ghost_pend_r <= 1'b0;
      q_r          <= QSEL_GHOST;
      idx_r        <= '0;
      found_r      <= FOUND_NONE;
    end else begin
      if (out_tvalid && out_tready && state_r != ST_DONE) res_v_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RECENT_CAP:   cap_r[QSEL_RECENT]   <= cfg_data;
          REG_FREQUENT_CAP: cap_r[QSEL_FREQUENT] <= cfg_data;
          REG_GHOST_CAP:    cap_r[QSEL_GHOST]    <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tready) begin
            busy_r  <= 1'b1;
            key_r   <= in_tdata;
            orig_r  <= in_tdata;
            q_r     <= QSEL_GHOST;
            idx_r   <= '0;
            found_r <= FOUND_NONE;
            state_r <= ST_RD;
          end
        end
        // issue read of entry idx_r, or move on to the next queue (append after the frequent queue)
        ST_RD: begin
          if (idx_r < cnt_r[q_r]) begin
            state_r <= ST_CMP;
          end else begin
            idx_r <= '0;
            unique case (q_r)
              QSEL_GHOST:    q_r <= QSEL_RECENT;
              QSEL_RECENT:   q_r <= QSEL_FREQUENT;
              default: begin
                q_r     <= QSEL_RECENT;
                state_r <= ST_APPEND;
              end
            endcase
          end
        end
        ST_CMP: begin
          if (rsel == orig_r) begin
            unique case (q_r)
              QSEL_GHOST:  found_r <= FOUND_GHOST;
              QSEL_RECENT: found_r <= FOUND_RECENT;
              default:     found_r <= FOUND_FREQUENT;
            endcase
            state_r <= ST_SH_RD;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= ST_RD;
          end
        end
        // close the gap after a removed key
        ST_SH_RD: begin
          if (idx_r + CW'(1) < cnt_r[q_r]) begin
            state_r <= ST_SH_WR;
          end else begin
            cnt_r[q_r] <= cnt_r[q_r] - CW'(1);
            q_r        <= QSEL_FREQUENT;
            state_r    <= ST_APPEND;
          end
        end
        ST_SH_WR: begin
          idx_r   <= idx_r + CW'(1);
          state_r <= ST_SH_RD;
        end
        // drop oldest if full, then write tail
        ST_APPEND: begin
          idx_r <= '0;
          if (cnt_r[q_r] >= cap_eff && cnt_r[q_r] != '0) begin
            state_r <= ST_DROP_RD;
          end else begin
            state_r <= ST_TAIL;
          end
        end
        ST_DROP_RD: state_r <= ST_DROP_WAIT;
        ST_DROP_WAIT: begin
          if (q_r == QSEL_RECENT) begin
            drop_r       <= rsel;
            ghost_pend_r <= 1'b1;
          end
          state_r <= ST_DROP_SH_RD;
        end
        ST_DROP_SH_RD: begin
          if (idx_r + CW'(1) < cnt_r[q_r]) begin
            state_r <= ST_DROP_SH_WR;
          end else begin
            cnt_r[q_r] <= cnt_r[q_r] - CW'(1);
            state_r    <= ST_TAIL;
          end
        end
        ST_DROP_SH_WR: begin
          idx_r   <= idx_r + CW'(1);
          state_r <= ST_DROP_SH_RD;
        end
        ST_TAIL: begin
          if (cnt_r[q_r] < DEPTH_C) cnt_r[q_r] <= cnt_r[q_r] + CW'(1);
          if (ghost_pend_r) begin
            ghost_pend_r <= 1'b0;
            key_r        <= drop_r;
            q_r          <= QSEL_GHOST;
            state_r      <= ST_APPEND;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res_v_r || out_tready) begin
            res_v_r     <= 1'b1;
            res_found_r <= found_r;
            busy_r      <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_cnt_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= DEPTH_C && cnt_r[1] <= DEPTH_C && cnt_r[2] <= DEPTH_C)
    else $error("queue fill beyond depth");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_tready)
    else $error("ready while working");
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && (!res_v_r || out_tready) |=> res_v_r && state_r == ST_IDLE)
    else $error("result not loaded");

endmodule
